@@ hw/rtl/amgs_pkg.sv @@
package amgs_pkg;

  localparam int MAX_SLOTS     = 64;
  localparam int MAX_VERTEX_ID = 255;

  localparam int KIND_W   = 3;
  localparam int ID_W     = 8;
  localparam int LABEL_W  = 16;
  localparam int DEG_W    = 8;
  localparam int VTOT_W   = 7;

  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int ID_DEPTH = 1 << ID_W;
  localparam int CELL_W   = LABEL_W + 1;
  localparam int CELL_AW  = 2 * SLOT_W;
  localparam int CELL_DEPTH = MAX_SLOTS * MAX_SLOTS;

  typedef enum logic [KIND_W-1:0] {
    K_ADD_VERTEX = 3'd0,
    K_ADD_EDGE   = 3'd1,
    K_REMOVE     = 3'd2,
    K_DEGREE     = 3'd3,
    K_WEIGHT     = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    C_NOP   = 5'd0,
    C_LOAD  = 5'd1,
    C_RDA   = 5'd2,
    C_RDB   = 5'd3,
    C_GETB  = 5'd4,
    C_ADDV  = 5'd5,
    C_CLRR  = 5'd6,
    C_CLRC  = 5'd7,
    C_ERD   = 5'd8,
    C_ECHK  = 5'd9,
    C_EW1   = 5'd10,
    C_EW2   = 5'd11,
    C_RMV   = 5'd12,
    C_SID   = 5'd13,
    C_MOVID = 5'd14,
    C_MVRD  = 5'd15,
    C_MVW1  = 5'd16,
    C_MVW2  = 5'd17,
    C_DSET  = 5'd18,
    C_DRD   = 5'd19,
    C_DACC  = 5'd20,
    C_FIN   = 5'd21
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              add_ok;
    logic              a_ok;
    logic              b_ok;
    logic              cell_valid;
    logic              su_is_last;
    logic              clr_done;
    logic              mv_done;
    logic              deg_done;
    logic              deg_again;
    logic              out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/amgs_ifs.sv @@
interface amgs_in_if;
  logic                            valid;
  logic                            ready;
  logic [amgs_pkg::KIND_W-1:0]     kind;
  logic [amgs_pkg::ID_W-1:0]       vertex_id;
  logic [amgs_pkg::ID_W-1:0]       other_vertex_id;
  logic [amgs_pkg::LABEL_W-1:0]    edge_label;

  modport source (output valid, kind, vertex_id, other_vertex_id, edge_label, input ready);
  modport sink (input valid, kind, vertex_id, other_vertex_id, edge_label, output ready);
endinterface

interface amgs_out_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [amgs_pkg::DEG_W-1:0]      degree_or_weight;
  logic [amgs_pkg::LABEL_W-1:0]    stored_edge_label;
  logic [amgs_pkg::VTOT_W-1:0]     vertex_total;

  modport source (output valid, status, degree_or_weight, stored_edge_label, vertex_total,
                  input ready);
  modport sink (input valid, status, degree_or_weight, stored_edge_label, vertex_total,
                output ready);
endinterface

@@ hw/rtl/adjacency_matrix_graph_store.sv @@
// Requests are taken one at a time, only while idle. Each is latched and looked up,
//   then handled by kind: add vertex clears the new slot's row and column, add edge
//   writes both mirrored cells if free, remove vertex moves the last slot into the
//   freed one, degree scans one row, weight checks the cell and scans both rows.
// Reset (rst_n low, synchronous): clears the vertex count and id presence flags;
//   matrix cells of a slot are cleared when that slot is allocated.
module adjacency_matrix_graph_store (
  input  logic             clk,
  input  logic             rst_n,
  amgs_in_if.sink          in_ch,
  amgs_out_if.source       out_ch
);

  amgs_pkg::cmd_t       cmd;
  amgs_pkg::dp_status_t st;

  amgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  amgs_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .st                    (st),
    .in_kind               (in_ch.kind),
    .in_vertex_id          (in_ch.vertex_id),
    .in_other_vertex_id    (in_ch.other_vertex_id),
    .in_edge_label         (in_ch.edge_label),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_status            (out_ch.status),
    .out_degree_or_weight  (out_ch.degree_or_weight),
    .out_stored_edge_label (out_ch.stored_edge_label),
    .out_vertex_total      (out_ch.vertex_total)
  );

endmodule

@@ hw/rtl/amgs_ram.sv @@
module amgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/amgs_ctrl.sv @@
module amgs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  amgs_pkg::dp_status_t st,
  output amgs_pkg::cmd_t       cmd
);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_LKA   = 22'h000002,
    S_LKB   = 22'h000004,
    S_LKC   = 22'h000008,
    S_DISP  = 22'h000010,
    S_ADDV  = 22'h000020,
    S_CLRR  = 22'h000040,
    S_CLRC  = 22'h000080,
    S_ERD   = 22'h000100,
    S_ECHK  = 22'h000200,
    S_EW1   = 22'h000400,
    S_EW2   = 22'h000800,
    S_RMV   = 22'h001000,
    S_SID   = 22'h002000,
    S_MOVID = 22'h004000,
    S_MVRD  = 22'h008000,
    S_MVW1  = 22'h010000,
    S_MVW2  = 22'h020000,
    S_DSET  = 22'h040000,
    S_DRD   = 22'h080000,
    S_DACC  = 22'h100000,
    S_FIN   = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = amgs_pkg::C_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = amgs_pkg::C_LOAD;
          state_nxt = S_LKA;
        end
      end
      S_LKA: begin
        cmd       = amgs_pkg::C_RDA;
        state_nxt = S_LKB;
      end
      S_LKB: begin
        cmd       = amgs_pkg::C_RDB;
        state_nxt = S_LKC;
      end
      S_LKC: begin
        cmd       = amgs_pkg::C_GETB;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        case (st.kind)
          amgs_pkg::K_ADD_VERTEX: state_nxt = st.add_ok ? S_ADDV : S_FIN;
          amgs_pkg::K_ADD_EDGE:   state_nxt = (st.a_ok && st.b_ok) ? S_ERD : S_FIN;
          amgs_pkg::K_REMOVE:     state_nxt = st.a_ok ? S_RMV : S_FIN;
          amgs_pkg::K_DEGREE:     state_nxt = st.a_ok ? S_DSET : S_FIN;
          amgs_pkg::K_WEIGHT:     state_nxt = (st.a_ok && st.b_ok) ? S_ERD : S_FIN;
          default:                state_nxt = S_FIN;
        endcase
      end
      S_ADDV: begin
        cmd       = amgs_pkg::C_ADDV;
        state_nxt = S_CLRR;
      end
      S_CLRR: begin
        cmd       = amgs_pkg::C_CLRR;
        state_nxt = S_CLRC;
      end
      S_CLRC: begin
        cmd       = amgs_pkg::C_CLRC;
        state_nxt = st.clr_done ? S_FIN : S_CLRR;
      end
      S_ERD: begin
        cmd       = amgs_pkg::C_ERD;
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        cmd = amgs_pkg::C_ECHK;
        if (st.kind == amgs_pkg::K_ADD_EDGE) begin
          state_nxt = st.cell_valid ? S_FIN : S_EW1;
        end else begin
          state_nxt = st.cell_valid ? S_DSET : S_FIN;
        end
      end
      S_EW1: begin
        cmd       = amgs_pkg::C_EW1;
        state_nxt = S_EW2;
      end
      S_EW2: begin
        cmd       = amgs_pkg::C_EW2;
        state_nxt = S_FIN;
      end
      S_RMV: begin
        cmd       = amgs_pkg::C_RMV;
        state_nxt = st.su_is_last ? S_FIN : S_SID;
      end
      S_SID: begin
        cmd       = amgs_pkg::C_SID;
        state_nxt = S_MOVID;
      end
      S_MOVID: begin
        cmd       = amgs_pkg::C_MOVID;
        state_nxt = S_MVRD;
      end
      S_MVRD: begin
        cmd       = amgs_pkg::C_MVRD;
        state_nxt = S_MVW1;
      end
      S_MVW1: begin
        cmd       = amgs_pkg::C_MVW1;
        state_nxt = S_MVW2;
      end
      S_MVW2: begin
        cmd       = amgs_pkg::C_MVW2;
        state_nxt = st.mv_done ? S_FIN : S_MVRD;
      end
      S_DSET: begin
        cmd       = amgs_pkg::C_DSET;
        state_nxt = S_DRD;
      end
      S_DRD: begin
        cmd       = amgs_pkg::C_DRD;
        state_nxt = S_DACC;
      end
      S_DACC: begin
        cmd = amgs_pkg::C_DACC;
        if (st.deg_done) begin
          state_nxt = st.deg_again ? S_DSET : S_FIN;
        end else begin
          state_nxt = S_DRD;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd       = amgs_pkg::C_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/amgs_dp.sv @@
module amgs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  amgs_pkg::cmd_t                cmd,
  output amgs_pkg::dp_status_t          st,
  input  logic [amgs_pkg::KIND_W-1:0]   in_kind,
  input  logic [amgs_pkg::ID_W-1:0]     in_vertex_id,
  input  logic [amgs_pkg::ID_W-1:0]     in_other_vertex_id,
  input  logic [amgs_pkg::LABEL_W-1:0]  in_edge_label,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [amgs_pkg::DEG_W-1:0]    out_degree_or_weight,
  output logic [amgs_pkg::LABEL_W-1:0]  out_stored_edge_label,
  output logic [amgs_pkg::VTOT_W-1:0]   out_vertex_total
);

  localparam int SW = amgs_pkg::SLOT_W;
  localparam int CW = amgs_pkg::CNT_W;

  logic [amgs_pkg::KIND_W-1:0]  kind_r;
  logic [amgs_pkg::ID_W-1:0]    a_r, b_r;
  logic [amgs_pkg::LABEL_W-1:0] label_r;
  logic [SW-1:0]                su_r, sv_r, tgt_r, last_r, deg_s_r;
  logic                         a_ok_r, b_ok_r;
  logic [CW-1:0]                count_r, idx_r;
  logic [amgs_pkg::DEG_W-1:0]   acc_r;
  logic                         stat_r;
  logic [amgs_pkg::LABEL_W-1:0] lab_r;
  logic [amgs_pkg::CELL_W-1:0]  cell_r;
  logic                         deg_pass_r, deg_sel_r;
  logic [amgs_pkg::ID_DEPTH-1:0] present_r;

  logic                          out_valid_r, out_status_r;
  logic [amgs_pkg::DEG_W-1:0]    out_dw_r;
  logic [amgs_pkg::LABEL_W-1:0]  out_lab_r;
  logic [amgs_pkg::VTOT_W-1:0]   out_vt_r;

  logic                        id_we;
  logic [amgs_pkg::ID_W-1:0]   id_waddr, id_raddr;
  logic [SW-1:0]               id_wdata, id_rdata;
  logic                        sl_we;
  logic [SW-1:0]               sl_waddr;
  logic [amgs_pkg::ID_W-1:0]   sl_wdata, sl_rdata;
  logic                        ce_we;
  logic [amgs_pkg::CELL_AW-1:0] ce_waddr, ce_raddr;
  logic [amgs_pkg::CELL_W-1:0] ce_wdata, ce_rdata;

  logic [SW-1:0] idx_s;
  logic [CW-1:0] idx_inc, count_dec;
  logic          idx_is_su, out_free;

  assign idx_s     = idx_r[SW-1:0];
  assign idx_inc   = idx_r + CW'(1);
  assign count_dec = count_r - CW'(1);
  assign idx_is_su = (idx_s == su_r);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    st.kind       = kind_r;
    st.add_ok     = (count_r < CW'(amgs_pkg::MAX_SLOTS))
                    && (int'(a_r) <= amgs_pkg::MAX_VERTEX_ID) && !present_r[a_r];
    st.a_ok       = a_ok_r;
    st.b_ok       = b_ok_r;
    st.cell_valid = ce_rdata[amgs_pkg::CELL_W-1];
    st.su_is_last = (su_r == count_dec[SW-1:0]);
    st.clr_done   = (idx_s == tgt_r);
    st.mv_done    = (idx_inc == CW'(last_r));
    st.deg_done   = (idx_inc == count_r);
    st.deg_again  = (kind_r == amgs_pkg::K_WEIGHT) && !deg_sel_r;
    st.out_free   = out_free;
  end

  always_comb begin
    id_we    = 1'b0;
    id_waddr = a_r;
    id_wdata = count_r[SW-1:0];
    id_raddr = (cmd == amgs_pkg::C_RDA) ? a_r : b_r;
    sl_we    = 1'b0;
    sl_waddr = count_r[SW-1:0];
    sl_wdata = a_r;
    ce_we    = 1'b0;
    ce_waddr = {tgt_r, idx_s};
    ce_wdata = '0;
    ce_raddr = {su_r, sv_r};
    case (cmd)
      amgs_pkg::C_ADDV: begin
        id_we = 1'b1;
        sl_we = 1'b1;
      end
      amgs_pkg::C_CLRR: ce_we = 1'b1;
      amgs_pkg::C_CLRC: begin
        ce_we    = 1'b1;
        ce_waddr = {idx_s, tgt_r};
      end
      amgs_pkg::C_EW1: begin
        ce_we    = 1'b1;
        ce_waddr = {su_r, sv_r};
        ce_wdata = {1'b1, label_r};
      end
      amgs_pkg::C_EW2: begin
        ce_we    = 1'b1;
        ce_waddr = {sv_r, su_r};
        ce_wdata = {1'b1, label_r};
      end
      amgs_pkg::C_MOVID: begin
        id_we    = 1'b1;
        id_waddr = sl_rdata;
        id_wdata = su_r;
        sl_we    = 1'b1;
        sl_waddr = su_r;
        sl_wdata = sl_rdata;
      end
      amgs_pkg::C_MVRD: ce_raddr = {last_r, idx_is_su ? last_r : idx_s};
      amgs_pkg::C_MVW1: begin
        ce_we    = 1'b1;
        ce_waddr = {su_r, idx_s};
        ce_wdata = ce_rdata;
      end
      amgs_pkg::C_MVW2: begin
        ce_we    = !idx_is_su;
        ce_waddr = {idx_s, su_r};
        ce_wdata = cell_r;
      end
      amgs_pkg::C_DRD: ce_raddr = {deg_s_r, idx_s};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd)
      amgs_pkg::C_LOAD: begin
        kind_r     <= in_kind;
        a_r        <= in_vertex_id;
        b_r        <= in_other_vertex_id;
        label_r    <= in_edge_label;
        acc_r      <= '0;
        lab_r      <= '0;
        stat_r     <= 1'b1;
        deg_pass_r <= 1'b0;
        deg_sel_r  <= 1'b0;
      end
      amgs_pkg::C_RDB: begin
        su_r   <= id_rdata;
        a_ok_r <= present_r[a_r] && (int'(a_r) <= amgs_pkg::MAX_VERTEX_ID);
      end
      amgs_pkg::C_GETB: begin
        sv_r   <= id_rdata;
        b_ok_r <= present_r[b_r] && (int'(b_r) <= amgs_pkg::MAX_VERTEX_ID);
      end
      amgs_pkg::C_ADDV: begin
        tgt_r  <= count_r[SW-1:0];
        idx_r  <= '0;
        stat_r <= 1'b0;
      end
      amgs_pkg::C_CLRC: idx_r <= idx_inc;
      amgs_pkg::C_ECHK: begin
        if (ce_rdata[amgs_pkg::CELL_W-1] && (kind_r == amgs_pkg::K_WEIGHT)) begin
          lab_r <= ce_rdata[amgs_pkg::LABEL_W-1:0];
        end
      end
      amgs_pkg::C_EW2: stat_r <= 1'b0;
      amgs_pkg::C_RMV: begin
        last_r <= count_dec[SW-1:0];
        stat_r <= 1'b0;
      end
      amgs_pkg::C_MOVID: idx_r <= '0;
      amgs_pkg::C_MVW1: cell_r <= ce_rdata;
      amgs_pkg::C_MVW2: idx_r <= idx_inc;
      amgs_pkg::C_DSET: begin
        deg_s_r    <= deg_pass_r ? sv_r : su_r;
        deg_sel_r  <= deg_pass_r;
        deg_pass_r <= 1'b1;
        idx_r      <= '0;
        stat_r     <= 1'b0;
      end
      amgs_pkg::C_DACC: begin
        if (ce_rdata[amgs_pkg::CELL_W-1]) begin
          acc_r <= acc_r + ((idx_s == deg_s_r) ? amgs_pkg::DEG_W'(2) : amgs_pkg::DEG_W'(1));
        end
        idx_r <= idx_inc;
      end
      amgs_pkg::C_FIN: begin
        out_status_r <= stat_r;
        out_dw_r     <= acc_r;
        out_lab_r    <= lab_r;
        out_vt_r     <= amgs_pkg::VTOT_W'(count_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == amgs_pkg::C_ADDV) begin
        count_r      <= count_r + CW'(1);
        present_r[a_r] <= 1'b1;
      end else if (cmd == amgs_pkg::C_RMV) begin
        count_r      <= count_dec;
        present_r[a_r] <= 1'b0;
      end
      if (cmd == amgs_pkg::C_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_degree_or_weight  = out_dw_r;
  assign out_stored_edge_label = out_lab_r;
  assign out_vertex_total      = out_vt_r;

  amgs_ram #(.WIDTH(SW), .DEPTH(amgs_pkg::ID_DEPTH)) u_id_ram (
    .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .raddr(id_raddr), .rdata(id_rdata)
  );

  amgs_ram #(.WIDTH(amgs_pkg::ID_W), .DEPTH(amgs_pkg::MAX_SLOTS)) u_slot_ram (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(last_r), .rdata(sl_rdata)
  );

  amgs_ram #(.WIDTH(amgs_pkg::CELL_W), .DEPTH(amgs_pkg::CELL_DEPTH)) u_cell_ram (
    .clk(clk), .we(ce_we), .waddr(ce_waddr), .wdata(ce_wdata),
    .raddr(ce_raddr), .rdata(ce_rdata)
  );

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(amgs_pkg::MAX_SLOTS))
    else $error("vertex count beyond slot capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1))
             || (count_r == $past(count_r) - CW'(1)))
    else $error("vertex count moved by more than one");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == amgs_pkg::C_FIN) && stat_r |=> (out_dw_r == '0) && (out_lab_r == '0))
    else $error("ignored request carries nonzero result");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == amgs_pkg::C_FIN) |-> out_free)
    else $error("result overwritten before transfer");

endmodule

@@ tb/adjacency_matrix_graph_store_test.sv @@
module adjacency_matrix_graph_store_test;
  timeunit 1ns;
  timeprecision 1ps;
  import amgs_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    vertex_id;
    logic [ID_W-1:0]    other_vertex_id;
    logic [LABEL_W-1:0] edge_label;
  } request_t;

  typedef struct packed {
    logic               status;
    logic [DEG_W-1:0]   degree_or_weight;
    logic [LABEL_W-1:0] stored_edge_label;
    logic [VTOT_W-1:0]  vertex_total;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  amgs_in_if  in_ch ();
  amgs_out_if out_ch ();

  adjacency_matrix_graph_store dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // graph shadow
  bit          present [ID_DEPTH];
  int          slot_of [ID_DEPTH];
  int          id_in_slot [MAX_SLOTS];
  bit          edge_on [MAX_SLOTS][MAX_SLOTS];
  logic [15:0] edge_tag [MAX_SLOTS][MAX_SLOTS];
  int          vertices;

  reply_t replies_due[$];
  int     errors = 0;
  int     sent = 0;
  int     replies_seen = 0;
  int     idle_cycles = 0;
  bit     hold_off = 1'b0;
  bit     sender_steady = 1'b0;
  bit     receiver_steady = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int vertex_degree(int s);
    int d;
    d = 0;
    for (int j = 0; j < vertices; j++) begin
      if (edge_on[s][j]) d += (j == s) ? 2 : 1;
    end
    return d;
  endfunction

  function automatic void wipe_line(int s);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      edge_on[s][i] = 1'b0; edge_tag[s][i] = '0;
      edge_on[i][s] = 1'b0; edge_tag[i][s] = '0;
    end
  endfunction

  function automatic reply_t apply_request(request_t r);
    reply_t rp;
    int su, sv, last, moved, v;
    bit ok_a, ok_b;
    rp = '0;
    rp.status = 1'b1;
    v = 0;
    ok_a = present[r.vertex_id];
    ok_b = present[r.other_vertex_id];
    su = slot_of[r.vertex_id];
    sv = slot_of[r.other_vertex_id];
    case (r.kind)
      K_ADD_VERTEX: begin
        if (vertices < MAX_SLOTS && !ok_a) begin
          present[r.vertex_id] = 1'b1;
          slot_of[r.vertex_id] = vertices;
          id_in_slot[vertices] = r.vertex_id;
          vertices++;
          rp.status = 1'b0;
        end
      end
      K_ADD_EDGE: begin
        if (ok_a && ok_b && !edge_on[su][sv]) begin
          edge_on[su][sv] = 1'b1; edge_tag[su][sv] = r.edge_label;
          edge_on[sv][su] = 1'b1; edge_tag[sv][su] = r.edge_label;
          rp.status = 1'b0;
        end
      end
      K_REMOVE: begin
        if (ok_a) begin
          last = vertices - 1;
          wipe_line(su);
          present[r.vertex_id] = 1'b0;
          slot_of[r.vertex_id] = 0;
          if (su != last) begin
            moved = id_in_slot[last];
            slot_of[moved] = su;
            id_in_slot[su] = moved;
            for (int i = 0; i < vertices; i++) begin
              if (i != su && i != last) begin
                edge_on[su][i] = edge_on[last][i]; edge_tag[su][i] = edge_tag[last][i];
                edge_on[i][su] = edge_on[i][last]; edge_tag[i][su] = edge_tag[i][last];
              end
            end
            edge_on[su][su] = edge_on[last][last];
            edge_tag[su][su] = edge_tag[last][last];
          end
          id_in_slot[last] = 0;
          wipe_line(last);
          vertices--;
          rp.status = 1'b0;
        end
      end
      K_DEGREE: begin
        if (ok_a) begin
          v = vertex_degree(su);
          rp.status = 1'b0;
        end
      end
      K_WEIGHT: begin
        if (ok_a && ok_b && edge_on[su][sv]) begin
          v = vertex_degree(su) + vertex_degree(sv);
          rp.stored_edge_label = edge_tag[su][sv];
          rp.status = 1'b0;
        end
      end
      default: ;
    endcase
    rp.degree_or_weight = (v > 255) ? 8'd255 : v[7:0];
    rp.vertex_total = vertices[VTOT_W-1:0];
    return rp;
  endfunction

  task automatic send_request(request_t r);
    in_ch.valid <= 1'b1;
    in_ch.kind <= r.kind;
    in_ch.vertex_id <= r.vertex_id;
    in_ch.other_vertex_id <= r.other_vertex_id;
    in_ch.edge_label <= r.edge_label;
    do @(posedge clk); while (!in_ch.ready);
    replies_due.push_back(apply_request(r));
    sent++;
    @(negedge clk);
    if (!sender_steady && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic request_t make_request(int k, int a, int b, int lab);
    request_t r;
    r.kind = k[KIND_W-1:0];
    r.vertex_id = a[ID_W-1:0];
    r.other_vertex_id = b[ID_W-1:0];
    r.edge_label = lab[LABEL_W-1:0];
    return r;
  endfunction

  function automatic int known_id();
    int pick;
    pick = $urandom_range(0, 255);
    if (vertices > 0 && $urandom_range(0, 4) != 0) pick = id_in_slot[$urandom_range(0, vertices - 1)];
    return pick;
  endfunction

  task automatic idle_until_drained();
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply: got %p", $time, {out_ch.status,
          out_ch.degree_or_weight, out_ch.stored_edge_label, out_ch.vertex_total});
        errors++;
      end else begin
        reply_t want;
        want = replies_due.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_ch.status);
          errors++;
        end
        if (out_ch.degree_or_weight !== want.degree_or_weight) begin
          $display("%0t: degree_or_weight expected %0d got %0d", $time,
                   want.degree_or_weight, out_ch.degree_or_weight);
          errors++;
        end
        if (out_ch.stored_edge_label !== want.stored_edge_label) begin
          $display("%0t: stored_edge_label expected %h got %h", $time,
                   want.stored_edge_label, out_ch.stored_edge_label);
          errors++;
        end
        if (out_ch.vertex_total !== want.vertex_total) begin
          $display("%0t: vertex_total expected %0d got %0d", $time,
                   want.vertex_total, out_ch.vertex_total);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (receiver_steady) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 9) > 2);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("adjacency_matrix_graph_store test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(make_request(K_DEGREE, 0, 0, 0));
    send_request(make_request(K_ADD_VERTEX, 0, 0, 0));
    send_request(make_request(K_ADD_VERTEX, 255, 0, 0));
    send_request(make_request(K_ADD_VERTEX, 255, 0, 0));
    send_request(make_request(K_ADD_VERTEX, 7, 0, 0));
    send_request(make_request(K_ADD_EDGE, 0, 255, 16'hFFFF));
    send_request(make_request(K_ADD_EDGE, 255, 0, 16'h1234));
    send_request(make_request(K_ADD_EDGE, 7, 7, 16'hA5A5));
    send_request(make_request(K_ADD_EDGE, 0, 9, 16'h0001));
    send_request(make_request(K_DEGREE, 7, 0, 0));
    send_request(make_request(K_WEIGHT, 0, 255, 0));
    send_request(make_request(K_WEIGHT, 0, 7, 0));
    send_request(make_request(K_REMOVE, 0, 0, 0));
    send_request(make_request(K_DEGREE, 7, 0, 0));
    send_request(make_request(K_WEIGHT, 7, 7, 0));
    send_request(make_request(K_REMOVE, 0, 0, 0));
    for (int k = 5; k < 8; k++) send_request(make_request(k, 7, 7, 16'h5A5A));
    send_request(make_request(K_REMOVE, 7, 0, 0));
    send_request(make_request(K_REMOVE, 255, 0, 0));
    idle_until_drained();
  endtask

  task automatic test_full_store();
    for (int i = 0; i < MAX_SLOTS + 2; i++)
      send_request(make_request(K_ADD_VERTEX, 100 + i, 0, 0));
    for (int i = 0; i < 20; i++)
      send_request(make_request(K_ADD_EDGE, known_id(), known_id(), $urandom_range(0, 65535)));
    send_request(make_request(K_WEIGHT, known_id(), known_id(), 0));
    idle_until_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    sender_steady = 1'b1;
    fork
      begin
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_request(make_request(K_DEGREE, known_id(), 0, 0));
    join
    sender_steady = 1'b0;
    idle_until_drained();
  endtask

  task automatic test_random(int count);
    int k, roll;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) receiver_steady = 1'b1;
      if (n == count / 2 + 150) receiver_steady = 1'b0;
      sender_steady = (n / 100) % 4 == 1;
      roll = $urandom_range(0, 99);
      if (roll < 2) k = $urandom_range(5, 7);
      else if (roll < 22 + (vertices < 20 ? 15 : 0)) k = K_ADD_VERTEX;
      else if (roll < 50) k = K_ADD_EDGE;
      else if (roll < 62 - (vertices < 10 ? 8 : 0)) k = K_REMOVE;
      else if (roll < 80) k = K_DEGREE;
      else k = K_WEIGHT;
      send_request(make_request(k, known_id(), known_id(), $urandom_range(0, 65535)));
    end
    sender_steady = 1'b0;
    idle_until_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.vertex_id = '0;
    in_ch.other_vertex_id = '0;
    in_ch.edge_label = '0;
    for (int i = 0; i < ID_DEPTH; i++) begin
      present[i] = 1'b0; slot_of[i] = 0;
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      id_in_slot[i] = 0;
      for (int j = 0; j < MAX_SLOTS; j++) begin
        edge_on[i][j] = 1'b0; edge_tag[i][j] = '0;
      end
    end
    vertices = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_store();
    test_backpressure();
    test_random(1500);
    repeat (300) @(negedge clk);
    $display("covered %0d requests of every kind, %0d replies checked,", sent, replies_seen);
    $display("including a full store, removal swaps, self loops and a long output stall");
    if (errors == 0 && replies_due.size() == 0) begin
      $display("adjacency_matrix_graph_store test passed");
    end else begin
      $display("adjacency_matrix_graph_store test failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/amgs_pkg.sv
hw/rtl/amgs_ifs.sv
hw/rtl/amgs_ram.sv
hw/rtl/amgs_ctrl.sv
hw/rtl/amgs_dp.sv
hw/rtl/adjacency_matrix_graph_store.sv
tb/adjacency_matrix_graph_store_test.sv
